/* rtl/core/stl_pkg.sv */
// ----------------------------------------------------------------------------
// stl_pkg: shared types and constants for the script token lexer
// Token kinds, scan modes, keyword table and output saturation helpers.
// ----------------------------------------------------------------------------
package stl_pkg;

   localparam int OUT_POS_BITS = 24;
   localparam int OUT_LEN_BITS = 16;
   localparam int WIDE_POS_BITS = 48;
   localparam int WIDE_LEN_BITS = 32;

   localparam int FIFO_DEPTH = 4;
   localparam int FIFO_PTR_BITS = $clog2(FIFO_DEPTH);
   localparam int FIFO_CNT_BITS = $clog2(FIFO_DEPTH + 1);

   // token kinds
   localparam logic [4:0] KIND_EOF      = 5'd0;
   localparam logic [4:0] KIND_NUMBER   = 5'd1;
   localparam logic [4:0] KIND_STRING   = 5'd2;
   localparam logic [4:0] KIND_IDENT    = 5'd3;
   localparam logic [4:0] KIND_KEYWORD0 = 5'd4;
   localparam logic [4:0] KIND_PLUS     = 5'd12;
   localparam logic [4:0] KIND_MINUS    = 5'd13;
   localparam logic [4:0] KIND_STAR     = 5'd14;
   localparam logic [4:0] KIND_SLASH    = 5'd15;
   localparam logic [4:0] KIND_LPAREN   = 5'd16;
   localparam logic [4:0] KIND_RPAREN   = 5'd17;
   localparam logic [4:0] KIND_LBRACE   = 5'd18;
   localparam logic [4:0] KIND_RBRACE   = 5'd19;
   localparam logic [4:0] KIND_SEMI     = 5'd20;
   localparam logic [4:0] KIND_COMMA    = 5'd21;
   localparam logic [4:0] KIND_ASSIGN   = 5'd22;
   localparam logic [4:0] KIND_EQEQ     = 5'd23;
   localparam logic [4:0] KIND_UNKNOWN  = 5'd24;

   typedef enum logic [2:0] {
      MODE_IDLE    = 3'd0,
      MODE_NUMBER  = 3'd1,
      MODE_IDENT   = 3'd2,
      MODE_STRING  = 3'd3,
      MODE_SLASH   = 3'd4,
      MODE_EQUALS  = 3'd5,
      MODE_COMMENT = 3'd6
   } mode_type;

   localparam int KW_COUNT = 8;

   localparam logic [7:0] KW_TEXT [KW_COUNT][8] = '{
      '{"v", "a", "r", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
      '{"l", "e", "t", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
      '{"c", "o", "n", "s", "t", 8'h00, 8'h00, 8'h00},
      '{"i", "f", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
      '{"e", "l", "s", "e", 8'h00, 8'h00, 8'h00, 8'h00},
      '{"w", "h", "i", "l", "e", 8'h00, 8'h00, 8'h00},
      '{"f", "u", "n", "c", "t", "i", "o", "n"},
      '{"r", "e", "t", "u", "r", "n", 8'h00, 8'h00}
   };

   localparam logic [3:0] KW_LEN [KW_COUNT] = '{
      4'd3, 4'd3, 4'd5, 4'd2, 4'd4, 4'd5, 4'd8, 4'd6
   };

   typedef struct packed {
      logic [4:0]              kind;
      logic [OUT_POS_BITS-1:0] line;
      logic [OUT_POS_BITS-1:0] start;
      logic [OUT_LEN_BITS-1:0] length;
      logic                    last;
   } token_type;

   typedef struct packed {
      logic      v0;
      logic      v1;
      token_type e0;
      token_type e1;
   } push_type;

   function automatic logic [OUT_POS_BITS-1:0] sat_pos(input logic [WIDE_POS_BITS-1:0] v);
      logic [OUT_POS_BITS-1:0] r;
      r = (|v[WIDE_POS_BITS-1:OUT_POS_BITS]) ? '1 : v[OUT_POS_BITS-1:0];
      return r;
   endfunction

   function automatic logic [OUT_LEN_BITS-1:0] sat_len(input logic [WIDE_LEN_BITS-1:0] v);
      logic [OUT_LEN_BITS-1:0] r;
      r = (|v[WIDE_LEN_BITS-1:OUT_LEN_BITS]) ? '1 : v[OUT_LEN_BITS-1:0];
      return r;
   endfunction

endpackage

/* rtl/core/script_token_lexer.sv */
// ----------------------------------------------------------------------------
// script_token_lexer: streaming tokenizer for a small script language
// Tokens of an accepted byte are registered in the token queue for rsp.
// Throughput: one source byte per cycle while req_tready is high; rsp moves
// one token per cycle while rsp_tready is high, through a four-entry queue.
// req_tready drops while the queue has fewer than two free entries.
// Reset: synchronous; scanner returns to idle at line 1, offset 0, queue empty.
// ----------------------------------------------------------------------------
module script_token_lexer
   import stl_pkg::*;
#(
   parameter int POSITION_BITS = 24,
   parameter int LENGTH_BITS   = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] source_byte
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [71:0] rsp_tdata,   // [4:0] token_kind, [28:5] token_line,
                                    // [52:29] token_start, [68:53] token_length
   output logic        rsp_tlast    // last_of_run
);

   push_type  push;
   token_type head;
   logic      room_for_two;
   logic      step;

   assign req_tready = room_for_two;
   assign step       = req_tvalid && req_tready;

   stl_scan #(
      .POSITION_BITS (POSITION_BITS),
      .LENGTH_BITS   (LENGTH_BITS)
   ) u_scan (
      .clock   (clock),
      .reset   (reset),
      .step    (step),
      .byte_in (req_tdata),
      .push    (push)
   );

   stl_fifo u_fifo (
      .clock        (clock),
      .reset        (reset),
      .push         (push),
      .room_for_two (room_for_two),
      .out_valid    (rsp_tvalid),
      .out_ready    (rsp_tready),
      .out_token    (head)
   );

   assign rsp_tdata = {3'b000, head.length, head.start, head.line, head.kind};
   assign rsp_tlast = head.last;

endmodule

/* rtl/core/stl_scan.sv */
// ----------------------------------------------------------------------------
// stl_scan: per-byte scanner
// Holds the lexer state and turns one source byte into up to two tokens.
// ----------------------------------------------------------------------------
module stl_scan
   import stl_pkg::*;
#(
   parameter int POSITION_BITS = 24,
   parameter int LENGTH_BITS   = 16
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       step,
   input  logic [7:0] byte_in,
   output push_type   push
);

   mode_type                 mode_ff, mode_in;
   logic                     quote_ff, quote_in;
   logic [POSITION_BITS-1:0] pos_ff, pos_in;
   logic [POSITION_BITS-1:0] line_ff, line_in;
   logic [POSITION_BITS-1:0] pstart_ff, pstart_in;
   logic [POSITION_BITS-1:0] pline_ff, pline_in;
   logic [LENGTH_BITS-1:0]   plen_ff, plen_in;
   logic [KW_COUNT-1:0]      cand_ff, cand_in;

   logic [POSITION_BITS-1:0] pos_inc, line_inc;
   logic [LENGTH_BITS-1:0]   plen_inc;
   logic [KW_COUNT-1:0]      cont_cand, new_cand;
   logic [4:0]               ident_kind;
   logic                     byte_digit, byte_letter, byte_blank, is_nl, close_quote;
   logic                     flushable, fa, fb, do_idle;
   token_type                tok_a, tok_b;

   assign pos_inc  = (&pos_ff) ? pos_ff : pos_ff + 1'b1;
   assign line_inc = (&line_ff) ? line_ff : line_ff + 1'b1;
   assign plen_inc = (&plen_ff) ? plen_ff : plen_ff + 1'b1;

   assign byte_digit  = (byte_in >= "0") && (byte_in <= "9");
   assign byte_letter = ((byte_in >= "a") && (byte_in <= "z")) ||
                        ((byte_in >= "A") && (byte_in <= "Z")) || (byte_in == "_");
   assign is_nl       = (byte_in == 8'h0a);
   assign byte_blank  = (byte_in == " ") || (byte_in == 8'h09) || (byte_in == 8'h0d) ||
                        is_nl;
   assign close_quote = quote_ff ? (byte_in == "'") : (byte_in == "\"");

   assign flushable = (mode_ff == MODE_NUMBER) || (mode_ff == MODE_IDENT) ||
                      (mode_ff == MODE_STRING) || (mode_ff == MODE_SLASH) ||
                      (mode_ff == MODE_EQUALS);

   // keyword candidate narrowing, one lane per keyword
   always_comb begin
      for (int k = 0; k < KW_COUNT; k++) begin
         cont_cand[k] = cand_ff[k] && (plen_ff < LENGTH_BITS'(8)) &&
                        (plen_ff < LENGTH_BITS'(KW_LEN[k])) &&
                        (KW_TEXT[k][plen_ff[2:0]] == byte_in);
         new_cand[k]  = (KW_TEXT[k][0] == byte_in);
      end
   end

   // lowest matching keyword wins
   always_comb begin
      ident_kind = KIND_IDENT;
      for (int k = KW_COUNT - 1; k >= 0; k--) begin
         if (cand_ff[k] && (plen_ff == LENGTH_BITS'(KW_LEN[k]))) begin
            ident_kind = KIND_KEYWORD0 + 5'(k);
         end
      end
   end

   // token held pending, flushed by this byte
   always_comb begin
      tok_a.line  = sat_pos(WIDE_POS_BITS'(pline_ff));
      tok_a.start = sat_pos(WIDE_POS_BITS'(pstart_ff));
      tok_a.last  = 1'b0;
      unique case (mode_ff)
         MODE_NUMBER: begin
            tok_a.kind   = KIND_NUMBER;
            tok_a.length = sat_len(WIDE_LEN_BITS'(plen_ff));
         end
         MODE_IDENT: begin
            tok_a.kind   = ident_kind;
            tok_a.length = sat_len(WIDE_LEN_BITS'(plen_ff));
         end
         MODE_STRING: begin
            tok_a.kind   = KIND_STRING;
            tok_a.length = sat_len(WIDE_LEN_BITS'(plen_ff));
         end
         MODE_SLASH: begin
            tok_a.kind   = KIND_SLASH;
            tok_a.length = OUT_LEN_BITS'(1);
         end
         default: begin
            tok_a.kind   = KIND_ASSIGN;
            tok_a.length = OUT_LEN_BITS'(1);
         end
      endcase
   end

   always_comb begin
      mode_in   = mode_ff;
      quote_in  = quote_ff;
      pos_in    = pos_inc;
      line_in   = line_ff;
      pstart_in = pstart_ff;
      pline_in  = pline_ff;
      plen_in   = plen_ff;
      cand_in   = cand_ff;
      fa        = 1'b0;
      fb        = 1'b0;
      do_idle   = 1'b0;
      tok_b.kind   = KIND_UNKNOWN;
      tok_b.line   = sat_pos(WIDE_POS_BITS'(line_ff));
      tok_b.start  = sat_pos(WIDE_POS_BITS'(pos_ff));
      tok_b.length = OUT_LEN_BITS'(1);
      tok_b.last   = 1'b1;

      if (byte_in == 8'h00) begin
         // end of source: flush, emit EOF, return to reset state
         fa           = flushable;
         fb           = 1'b1;
         tok_b.kind   = KIND_EOF;
         tok_b.length = '0;
         mode_in   = MODE_IDLE;
         quote_in  = 1'b0;
         pos_in    = '0;
         line_in   = POSITION_BITS'(1);
         pstart_in = '0;
         pline_in  = POSITION_BITS'(1);
         plen_in   = '0;
         cand_in   = '1;
      end else begin
         unique case (mode_ff)
            MODE_STRING: begin
               if (close_quote) begin
                  fa      = 1'b1;
                  mode_in = MODE_IDLE;
               end else begin
                  plen_in = plen_inc;
               end
            end
            MODE_COMMENT: begin
               if (is_nl) begin
                  line_in = line_inc;
                  mode_in = MODE_IDLE;
               end
            end
            MODE_NUMBER: begin
               if (byte_digit) begin
                  plen_in = plen_inc;
               end else begin
                  fa      = 1'b1;
                  do_idle = 1'b1;
               end
            end
            MODE_IDENT: begin
               if (byte_letter || byte_digit) begin
                  cand_in = cont_cand;
                  plen_in = plen_inc;
               end else begin
                  fa      = 1'b1;
                  do_idle = 1'b1;
               end
            end
            MODE_SLASH: begin
               if (byte_in == "/") begin
                  mode_in = MODE_COMMENT;
               end else begin
                  fa      = 1'b1;
                  do_idle = 1'b1;
               end
            end
            MODE_EQUALS: begin
               if (byte_in == "=") begin
                  fb           = 1'b1;
                  tok_b.kind   = KIND_EQEQ;
                  tok_b.line   = sat_pos(WIDE_POS_BITS'(pline_ff));
                  tok_b.start  = sat_pos(WIDE_POS_BITS'(pstart_ff));
                  tok_b.length = OUT_LEN_BITS'(2);
                  mode_in      = MODE_IDLE;
               end else begin
                  fa      = 1'b1;
                  do_idle = 1'b1;
               end
            end
            default: begin
               do_idle = 1'b1;
            end
         endcase

         if (do_idle) begin
            mode_in = MODE_IDLE;
            priority if (byte_blank) begin
               if (is_nl) begin
                  line_in = line_inc;
               end
            end else if (byte_digit) begin
               mode_in   = MODE_NUMBER;
               pstart_in = pos_ff;
               pline_in  = line_ff;
               plen_in   = LENGTH_BITS'(1);
            end else if ((byte_in == "\"") || (byte_in == "'")) begin
               quote_in  = (byte_in == "'");
               mode_in   = MODE_STRING;
               pstart_in = pos_inc;
               pline_in  = line_ff;
               plen_in   = '0;
            end else if (byte_letter) begin
               mode_in   = MODE_IDENT;
               pstart_in = pos_ff;
               pline_in  = line_ff;
               plen_in   = LENGTH_BITS'(1);
               cand_in   = new_cand;
            end else if (byte_in == "/") begin
               mode_in   = MODE_SLASH;
               pstart_in = pos_ff;
               pline_in  = line_ff;
               plen_in   = LENGTH_BITS'(1);
            end else if (byte_in == "=") begin
               mode_in   = MODE_EQUALS;
               pstart_in = pos_ff;
               pline_in  = line_ff;
               plen_in   = LENGTH_BITS'(1);
            end else begin
               fb = 1'b1;
               unique case (byte_in)
                  "+":     tok_b.kind = KIND_PLUS;
                  "-":     tok_b.kind = KIND_MINUS;
                  "*":     tok_b.kind = KIND_STAR;
                  "(":     tok_b.kind = KIND_LPAREN;
                  ")":     tok_b.kind = KIND_RPAREN;
                  "{":     tok_b.kind = KIND_LBRACE;
                  "}":     tok_b.kind = KIND_RBRACE;
                  ";":     tok_b.kind = KIND_SEMI;
                  ",":     tok_b.kind = KIND_COMMA;
                  default: tok_b.kind = KIND_UNKNOWN;
               endcase
            end
         end
      end
   end

   // compact the two slots; the final token of the byte carries last
   always_comb begin
      push.v0      = step && (fa || fb);
      push.v1      = step && fa && fb;
      push.e0      = fa ? tok_a : tok_b;
      push.e0.last = fa ? !fb : 1'b1;
      push.e1      = tok_b;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff   <= MODE_IDLE;
         quote_ff  <= 1'b0;
         pos_ff    <= '0;
         line_ff   <= POSITION_BITS'(1);
         pstart_ff <= '0;
         pline_ff  <= POSITION_BITS'(1);
         plen_ff   <= '0;
         cand_ff   <= '1;
      end else if (step) begin
         mode_ff   <= mode_in;
         quote_ff  <= quote_in;
         pos_ff    <= pos_in;
         line_ff   <= line_in;
         pstart_ff <= pstart_in;
         pline_ff  <= pline_in;
         plen_ff   <= plen_in;
         cand_ff   <= cand_in;
      end
   end

endmodule

/* rtl/core/stl_fifo.sv */
// ----------------------------------------------------------------------------
// stl_fifo: token result queue
// Takes up to two tokens a cycle; gives one a cycle while out_ready is high.
// ----------------------------------------------------------------------------
module stl_fifo
   import stl_pkg::*;
(
   input  logic      clock,
   input  logic      reset,
   input  push_type  push,
   output logic      room_for_two,
   output logic      out_valid,
   input  logic      out_ready,
   output token_type out_token
);

   token_type                slot_ff [FIFO_DEPTH];
   logic [FIFO_PTR_BITS-1:0] wr_ptr_ff, wr_ptr_in;
   logic [FIFO_PTR_BITS-1:0] rd_ptr_ff, rd_ptr_in;
   logic [FIFO_CNT_BITS-1:0] count_ff, count_in;
   logic [FIFO_PTR_BITS-1:0] wr_next;
   logic                     pop;
   logic [FIFO_CNT_BITS-1:0] n_push;

   assign out_valid    = (count_ff != '0);
   assign out_token    = slot_ff[rd_ptr_ff];
   assign room_for_two = (count_ff <= FIFO_CNT_BITS'(FIFO_DEPTH - 2));
   assign pop          = out_valid && out_ready;
   assign wr_next      = wr_ptr_ff + 1'b1;
   assign n_push       = FIFO_CNT_BITS'(push.v0) + FIFO_CNT_BITS'(push.v1);

   always_comb begin
      wr_ptr_in = wr_ptr_ff + FIFO_PTR_BITS'(n_push);
      rd_ptr_in = rd_ptr_ff + FIFO_PTR_BITS'(pop);
      count_in  = count_ff + n_push - FIFO_CNT_BITS'(pop);
   end

   always_ff @(posedge clock) begin
      if (push.v0) begin
         slot_ff[wr_ptr_ff] <= push.e0;
      end
      if (push.v1) begin
         slot_ff[wr_next] <= push.e1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= FIFO_CNT_BITS'(FIFO_DEPTH))
      else $error("token queue count beyond depth");

   a_pair_fits: assert property (@(posedge clock) disable iff (reset)
      push.v1 |-> (count_ff - FIFO_CNT_BITS'(pop)) <= FIFO_CNT_BITS'(FIFO_DEPTH - 2))
      else $error("token pair pushed without room");

   a_second_needs_first: assert property (@(posedge clock) disable iff (reset)
      push.v1 |-> push.v0)
      else $error("second token slot used without the first");

   a_drain: assert property (@(posedge clock) disable iff (reset)
      (pop && !push.v0) |=> count_ff == $past(count_ff) - 1'b1)
      else $error("token queue count did not drop on pop");

endmodule

/* tb/script_token_lexer_test.sv */
// ----------------------------------------------------------------------------
// script_token_lexer_test: self-checking bench for the script token lexer
// Streams short sources (directed corner cases, then random token mixes with
// noise, plus one long identifier and one long string) through the request
// channel. A scoreboard predicts each token and compares every response
// field by field. Both channels idle at random.
// ----------------------------------------------------------------------------
module script_token_lexer_test
   import stl_pkg::*;
();
   timeunit 1ns;
   timeprecision 1ps;

   localparam int POSITION_BITS = 24;
   localparam int LENGTH_BITS   = 16;
   localparam logic [7:0] END_OF_SOURCE = 8'h00;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [7:0]  req_tdata = 8'h00;      // [7:0] source_byte
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [71:0] rsp_tdata;              // [4:0] kind, [28:5] line, [52:29] start,
                                        // [68:53] length
   logic        rsp_tlast;              // last_of_run

   script_token_lexer #(
      .POSITION_BITS(POSITION_BITS),
      .LENGTH_BITS  (LENGTH_BITS)
   ) i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata (req_tdata),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata (rsp_tdata),
      .rsp_tlast (rsp_tlast)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   class token_scoreboard;
      mode_type                 mode;
      bit                       single_quote;
      logic [POSITION_BITS-1:0] offset;
      logic [POSITION_BITS-1:0] line_no;
      logic [POSITION_BITS-1:0] tok_start;
      logic [POSITION_BITS-1:0] tok_line;
      logic [LENGTH_BITS-1:0]   tok_length;
      logic [7:0]               kw_alive;
      token_type                awaited_tokens[$];
      string                    kw_word[8];
      int                       errors;

      function new();
         kw_word = '{"var", "let", "const", "if", "else", "while", "function", "return"};
         errors = 0;
         restart();
      endfunction

      function void restart();
         mode = MODE_IDLE;
         single_quote = 1'b0;
         offset = '0;
         line_no = POSITION_BITS'(1);
         tok_start = '0;
         tok_line = POSITION_BITS'(1);
         tok_length = '0;
         kw_alive = '1;
      endfunction

      function logic [POSITION_BITS-1:0] bump_pos(logic [POSITION_BITS-1:0] v);
         return (&v) ? v : v + 1'b1;
      endfunction

      function logic [LENGTH_BITS-1:0] bump_len(logic [LENGTH_BITS-1:0] v);
         return (&v) ? v : v + 1'b1;
      endfunction

      function bit digit_char(logic [7:0] c);
         return c >= "0" && c <= "9";
      endfunction

      function bit is_letter(logic [7:0] c);
         return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") || c == "_";
      endfunction

      function bit is_blank(logic [7:0] c);
         return c == " " || c == "\t" || c == "\r" || c == "\n";
      endfunction

      function void add(logic [4:0] kind, logic [POSITION_BITS-1:0] ln,
                        logic [POSITION_BITS-1:0] st, logic [LENGTH_BITS-1:0] len);
         token_type t;
         t.kind = kind;
         t.line = ln;
         t.start = st;
         t.length = len;
         t.last = 1'b0;
         awaited_tokens.push_back(t);
      endfunction

      // drop keywords whose next character does not match
      function void narrow(logic [7:0] c);
         for (int k = 0; k < 8; k++)
            if (!(tok_length < kw_word[k].len() && kw_word[k][tok_length] == c))
               kw_alive[k] = 1'b0;
      endfunction

      function logic [4:0] word_kind();
         for (int k = 0; k < 8; k++)
            if (kw_alive[k] && tok_length == kw_word[k].len())
               return KIND_KEYWORD0 + 5'(k);
         return KIND_IDENT;
      endfunction

      function void open(mode_type m, logic [POSITION_BITS-1:0] st,
                         logic [LENGTH_BITS-1:0] len);
         mode = m;
         tok_start = st;
         tok_line = line_no;
         tok_length = len;
      endfunction

      function void flush();
         case (mode)
            MODE_NUMBER: add(KIND_NUMBER, tok_line, tok_start, tok_length);
            MODE_IDENT:  add(word_kind(), tok_line, tok_start, tok_length);
            MODE_STRING: add(KIND_STRING, tok_line, tok_start, tok_length);
            MODE_SLASH:  add(KIND_SLASH, tok_line, tok_start, LENGTH_BITS'(1));
            MODE_EQUALS: add(KIND_ASSIGN, tok_line, tok_start, LENGTH_BITS'(1));
            default: ;
         endcase
         mode = MODE_IDLE;
      endfunction

      function void start_byte(logic [7:0] c);
         logic [4:0] kind;
         kind = KIND_UNKNOWN;
         mode = MODE_IDLE;
         if (is_blank(c)) begin
            if (c == "\n") line_no = bump_pos(line_no);
         end else if (digit_char(c)) begin
            open(MODE_NUMBER, offset, LENGTH_BITS'(1));
         end else if (c == "\"" || c == "'") begin
            single_quote = (c == "'");
            open(MODE_STRING, bump_pos(offset), '0);
         end else if (is_letter(c)) begin
            open(MODE_IDENT, offset, '0);
            kw_alive = '1;
            narrow(c);
            tok_length = LENGTH_BITS'(1);
         end else if (c == "/") begin
            open(MODE_SLASH, offset, LENGTH_BITS'(1));
         end else if (c == "=") begin
            open(MODE_EQUALS, offset, LENGTH_BITS'(1));
         end else begin
            case (c)
               "+": kind = KIND_PLUS;
               "-": kind = KIND_MINUS;
               "*": kind = KIND_STAR;
               "(": kind = KIND_LPAREN;
               ")": kind = KIND_RPAREN;
               "{": kind = KIND_LBRACE;
               "}": kind = KIND_RBRACE;
               ";": kind = KIND_SEMI;
               ",": kind = KIND_COMMA;
               default: ;
            endcase
            add(kind, line_no, offset, LENGTH_BITS'(1));
         end
      endfunction

      function void scan_byte(logic [7:0] c);
         int        first;
         logic [7:0] closing;
         token_type t;
         first = awaited_tokens.size();
         closing = single_quote ? "'" : "\"";
         if (c == END_OF_SOURCE) begin
            flush();
            add(KIND_EOF, line_no, offset, '0);
            restart();
         end else begin
            case (mode)
               MODE_STRING: begin
                  if (c == closing) flush();
                  else tok_length = bump_len(tok_length);
               end
               MODE_COMMENT: begin
                  if (c == "\n") begin
                     line_no = bump_pos(line_no);
                     mode = MODE_IDLE;
                  end
               end
               MODE_NUMBER: begin
                  if (digit_char(c)) begin
                     tok_length = bump_len(tok_length);
                  end else begin
                     flush();
                     start_byte(c);
                  end
               end
               MODE_IDENT: begin
                  if (is_letter(c) || digit_char(c)) begin
                     narrow(c);
                     tok_length = bump_len(tok_length);
                  end else begin
                     flush();
                     start_byte(c);
                  end
               end
               MODE_SLASH: begin
                  if (c == "/") begin
                     mode = MODE_COMMENT;
                  end else begin
                     flush();
                     start_byte(c);
                  end
               end
               MODE_EQUALS: begin
                  if (c == "=") begin
                     add(KIND_EQEQ, tok_line, tok_start, LENGTH_BITS'(2));
                     mode = MODE_IDLE;
                  end else begin
                     flush();
                     start_byte(c);
                  end
               end
               default: start_byte(c);
            endcase
            offset = bump_pos(offset);
         end
         // mark the final token of this request
         if (awaited_tokens.size() > first) begin
            t = awaited_tokens.pop_back();
            t.last = 1'b1;
            awaited_tokens.push_back(t);
         end
      endfunction

      function void check_token(logic [71:0] data, logic last);
         token_type want;
         if (awaited_tokens.size() == 0) begin
            $error("unexpected token: kind %0d, start %0d", data[4:0], data[52:29]);
            errors++;
            return;
         end
         want = awaited_tokens.pop_front();
         if (data[4:0] !== want.kind) begin
            $error("token_kind: expected %0d, got %0d", want.kind, data[4:0]);
            errors++;
         end
         if (data[28:5] !== want.line) begin
            $error("token_line: expected %0d, got %0d", want.line, data[28:5]);
            errors++;
         end
         if (data[52:29] !== want.start) begin
            $error("token_start: expected %0d, got %0d", want.start, data[52:29]);
            errors++;
         end
         if (data[68:53] !== want.length) begin
            $error("token_length: expected %0d, got %0d", want.length, data[68:53]);
            errors++;
         end
         if (last !== want.last) begin
            $error("last_of_run: expected %0d, got %0d", want.last, last);
            errors++;
         end
      endfunction
   endclass

   token_scoreboard sb;
   logic [7:0]      src_text[$];
   bit              steady = 1'b0;
   int              sent_count = 0;
   int              tokens_seen = 0;
   int              hold_left = 0;
   bit              hold_done = 1'b0;

   // ---- source text generation ----

   function automatic void put_text(string s);
      for (int i = 0; i < s.len(); i++) src_text.push_back(s[i]);
   endfunction

   function automatic logic [7:0] pick_letter();
      int r;
      r = $urandom_range(52);
      if (r < 26) return "a" + 8'(r);
      if (r < 52) return "A" + 8'(r - 26);
      return "_";
   endfunction

   function automatic logic [7:0] pick_alnum();
      if ($urandom_range(3) == 0) return "0" + 8'($urandom_range(9));
      return pick_letter();
   endfunction

   function automatic logic [7:0] pick_blank();
      string blanks;
      blanks = " \t\r\n";
      return blanks[$urandom_range(3)];
   endfunction

   function automatic logic [7:0] string_byte(logic [7:0] quote);
      logic [7:0] b;
      case ($urandom_range(5))
         0: b = "\n";
         1: b = (quote == "'") ? "\"" : "'";
         2: b = 8'($urandom_range(1, 255));
         default: b = pick_alnum();
      endcase
      return (b == quote) ? "." : b;
   endfunction

   function automatic void put_token();
      int         pick;
      logic [7:0] quote;
      logic [7:0] b;
      string      ops;
      ops = "+-*(){};,/<>";
      pick = $urandom_range(99);
      if (pick < 15) begin
         put_text(sb.kw_word[$urandom_range(7)]);
         // sometimes stretch or clip the keyword into a plain identifier
         case ($urandom_range(3))
            0: src_text.push_back(pick_alnum());
            1: void'(src_text.pop_back());
            default: ;
         endcase
      end else if (pick < 30) begin
         src_text.push_back(pick_letter());
         repeat ($urandom_range(5)) src_text.push_back(pick_alnum());
      end else if (pick < 42) begin
         repeat ($urandom_range(1, 5)) src_text.push_back("0" + 8'($urandom_range(9)));
      end else if (pick < 52) begin
         quote = $urandom_range(1) ? "'" : "\"";
         src_text.push_back(quote);
         repeat ($urandom_range(6)) src_text.push_back(string_byte(quote));
         src_text.push_back(quote);
      end else if (pick < 72) begin
         src_text.push_back(ops[$urandom_range(ops.len() - 1)]);
      end else if (pick < 80) begin
         src_text.push_back("=");
         if ($urandom_range(1)) src_text.push_back("=");
      end else if (pick < 88) begin
         put_text("//");
         repeat ($urandom_range(8)) begin
            b = 8'($urandom_range(1, 255));
            src_text.push_back(b == "\n" ? " " : b);
         end
         src_text.push_back("\n");
      end else if (pick < 96) begin
         repeat ($urandom_range(1, 3)) src_text.push_back(pick_blank());
      end else begin
         src_text.push_back(8'($urandom_range(1, 255)));
      end
   endfunction

   // ---- request side ----

   task automatic send_byte(input logic [7:0] b);
      steady = (sent_count >= 400 && sent_count < 650);
      if (!steady && $urandom_range(99) < 30) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 3)) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= b;
      do @(posedge clock); while (!req_tready);
      sb.scan_byte(b);
      sent_count++;
   endtask

   task automatic send_text();
      foreach (src_text[i]) send_byte(src_text[i]);
      src_text.delete();
   endtask

   task automatic wait_drained();
      req_tvalid <= 1'b0;
      do @(posedge clock); while (sb.awaited_tokens.size() != 0);
   endtask

   task automatic send_random_source();
      repeat ($urandom_range(1, 24)) begin
         put_token();
         if ($urandom_range(1)) src_text.push_back(pick_blank());
      end
      // occasionally leave a string open up to the end of source
      if ($urandom_range(9) == 0) begin
         src_text.push_back("\"");
         repeat ($urandom_range(4)) src_text.push_back(string_byte("\""));
      end
      src_text.push_back(END_OF_SOURCE);
      send_text();
   endtask

   // ---- response side ----

   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            sb.check_token(rsp_tdata, rsp_tlast);
            tokens_seen++;
         end
         // one long hold-off so the token queue fills and backs up requests
         if (!hold_done && tokens_seen >= 300) begin
            hold_done = 1'b1;
            hold_left = 400;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= steady || $urandom_range(99) >= 37;
         end
      end
   end

   initial begin
      int source_index;
      sb = new();
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // ident, ==, quoted text with a newline, slash held until end of source
      put_text("a=='x\ny'/");
      src_text.push_back(END_OF_SOURCE);
      send_text();
      // number cut by a comment, held = cut by a high byte, open string at end
      put_text("9//z\n=");
      src_text.push_back(8'hFF);
      src_text.push_back(8'h80);
      put_text("<\"ab");
      src_text.push_back(END_OF_SOURCE);
      send_text();
      // empty source
      send_byte(END_OF_SOURCE);

      source_index = 0;
      while (sent_count < 900) begin
         send_random_source();
         source_index++;
         if (source_index % 8 == 7) wait_drained();
      end

      // identifier that starts like a keyword and runs past every keyword length
      put_text("return");
      repeat (30) src_text.push_back(pick_alnum());
      src_text.push_back("+");
      // long string with uncounted newlines inside
      src_text.push_back("'");
      repeat (40) src_text.push_back(string_byte("'"));
      src_text.push_back("'");
      src_text.push_back(END_OF_SOURCE);
      send_text();

      req_tvalid <= 1'b0;
      do @(posedge clock); while (sb.awaited_tokens.size() != 0);
      repeat (20) @(posedge clock);
      if (sb.errors == 0) begin
         $display("[script_token_lexer] OK");
      end else begin
         $display("[script_token_lexer] ERROR");
      end
      $finish;
   end

   initial begin
      #10_000_000;
      $display("[script_token_lexer] ERROR");
      $finish;
   end

endmodule
